FILE: sv/bsa_pkg.sv
// Shared constants, codes and control types of the bitmap slot allocator.
`default_nettype none
package bsa_pkg;

   // Region geometry
   localparam int SLOT_COUNT = 4096;
   localparam int WORD_BITS  = 64;
   localparam int WORD_COUNT = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int ADDR_W     = $clog2(WORD_COUNT);
   localparam int COUNT_W    = SLOT_W + 1;
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 3;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MARK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NEW_MARK  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OLD_MARK  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OTHER     = 3'd4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic start;
      logic eval;
      logic out_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_read;
      logic eval_done;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

FILE: sv/bsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: sv/bsa_ctrl.sv
// Controller state machine of the bitmap slot allocator.
`default_nettype none
module bsa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bsa_pkg::sts_type sts,
   output bsa_pkg::cmd_type      cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_EVAL  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Decode commands and next state
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = sts.need_read ? S_EVAL : S_DONE;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.eval_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/bsa_datapath.sv
// Datapath of the bitmap slot allocator: bitmap RAM, row valid bits, cursor, count, result.
`default_nettype none
module bsa_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [bsa_pkg::COUNT_W-1:0]    csr_wr_data,
   input  wire logic [bsa_pkg::ACTION_W-1:0]   req_action,
   input  wire logic [bsa_pkg::SLOT_W-1:0]     req_slot_index,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [bsa_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [bsa_pkg::SLOT_W-1:0]     rsp_slot_found,
   output logic      [bsa_pkg::COUNT_W-1:0]    rsp_used_count,
   input  wire bsa_pkg::cmd_type               cmd,
   output bsa_pkg::sts_type                    sts
);

   localparam int WCNT_W = bsa_pkg::COUNT_W + 1 - bsa_pkg::BIT_W;

   // Control state
   logic [bsa_pkg::COUNT_W-1:0]    slots_ff, slots_in;
   logic [bsa_pkg::COUNT_W-1:0]    cursor_ff, cursor_in;
   logic [bsa_pkg::COUNT_W-1:0]    used_ff, used_in;
   logic [bsa_pkg::WORD_COUNT-1:0] valid_ff, valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [bsa_pkg::ACTION_W-1:0]   act_ff, act_in;
   logic [bsa_pkg::SLOT_W-1:0]     idx_ff, idx_in;
   logic [bsa_pkg::ADDR_W-1:0]     word_ff, word_in;
   logic [bsa_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [bsa_pkg::SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic [bsa_pkg::COUNT_W-1:0]    res_used_ff, res_used_in;
   logic [bsa_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [bsa_pkg::SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [bsa_pkg::COUNT_W-1:0]    rsp_used_ff, rsp_used_in;

   // RAM port signals
   logic                           wr_en, rd_en;
   logic [bsa_pkg::ADDR_W-1:0]     rd_addr;
   logic [bsa_pkg::WORD_BITS-1:0]  wr_data, rd_data;

   // Search signals
   logic [bsa_pkg::COUNT_W-1:0]    limit;
   logic [bsa_pkg::COUNT_W:0]      lim_round;
   logic [WCNT_W-1:0]              lw_ceil, word_next;
   logic [WCNT_W-2:0]              lw_full, word_ext;
   logic [bsa_pkg::ADDR_W-1:0]     cur_word;
   logic [bsa_pkg::WORD_BITS-1:0]  row, lo_mask, hi_mask, free_bits, set_bit;
   logic [bsa_pkg::BIT_W-1:0]      pos;
   logic                           found, more, mark_hit;
   logic [bsa_pkg::COUNT_W-1:0]    used_inc;

   bsa_ram #(
      .WIDTH (bsa_pkg::WORD_BITS),
      .DEPTH (bsa_pkg::WORD_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Saturate the slot limit and split it into words
   always_comb begin
      limit     = (slots_ff > bsa_pkg::COUNT_W'(bsa_pkg::SLOT_COUNT))
                  ? bsa_pkg::COUNT_W'(bsa_pkg::SLOT_COUNT) : slots_ff;
      lim_round = {1'b0, limit} + (bsa_pkg::COUNT_W + 1)'(bsa_pkg::WORD_BITS - 1);
      lw_ceil   = lim_round[bsa_pkg::COUNT_W:bsa_pkg::BIT_W];
      lw_full   = limit[bsa_pkg::COUNT_W-1:bsa_pkg::BIT_W];
      word_ext  = (WCNT_W - 1)'(word_ff);
      word_next = WCNT_W'(word_ff) + WCNT_W'(1);
      cur_word  = cursor_ff[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W];
      used_inc  = used_ff + bsa_pkg::COUNT_W'(1);
   end

   // Mask the fetched row and find its first free slot
   always_comb begin
      row = valid_ff[word_ff] ? rd_data : '0;
      if (word_ff == cur_word) begin
         lo_mask = ~((bsa_pkg::WORD_BITS'(1) << cursor_ff[bsa_pkg::BIT_W-1:0])
                     - bsa_pkg::WORD_BITS'(1));
      end else begin
         lo_mask = '1;
      end
      if (word_ext < lw_full) begin
         hi_mask = '1;
      end else if (word_ext == lw_full) begin
         hi_mask = (bsa_pkg::WORD_BITS'(1) << limit[bsa_pkg::BIT_W-1:0])
                   - bsa_pkg::WORD_BITS'(1);
      end else begin
         hi_mask = '0;
      end
      free_bits = ~row & lo_mask & hi_mask;
      found = 1'b0;
      pos   = '0;
      for (int i = bsa_pkg::WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            found = 1'b1;
            pos   = bsa_pkg::BIT_W'(i);
         end
      end
      more     = (word_next < lw_ceil);
      mark_hit = row[idx_ff[bsa_pkg::BIT_W-1:0]];
      if (act_ff == bsa_pkg::ACT_MARK) begin
         set_bit = bsa_pkg::WORD_BITS'(1) << idx_ff[bsa_pkg::BIT_W-1:0];
      end else begin
         set_bit = bsa_pkg::WORD_BITS'(1) << pos;
      end
      wr_data = row | set_bit;
   end

   // Report status to the controller
   always_comb begin
      if (act_ff == bsa_pkg::ACT_ALLOC) begin
         sts.need_read = (cursor_ff < limit);
      end else if (act_ff == bsa_pkg::ACT_MARK) begin
         sts.need_read = ({1'b0, idx_ff} < limit);
      end else begin
         sts.need_read = 1'b0;
      end
      sts.eval_done = (act_ff == bsa_pkg::ACT_MARK) || found || !more;
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Next state of the datapath
   always_comb begin
      slots_in      = slots_ff;
      cursor_in     = cursor_ff;
      used_in       = used_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      word_in       = word_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_used_in   = res_used_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_used_in   = rsp_used_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = word_ff;

      // Take a configuration write
      if (csr_wr_en) begin
         slots_in = csr_wr_data;
      end

      // Latch the accepted item
      if (cmd.accept) begin
         act_in = req_action;
         idx_in = req_slot_index;
      end

      // Decide the action: issue the first read or settle the result
      if (cmd.start) begin
         res_status_in = bsa_pkg::ST_OTHER;
         res_slot_in   = '0;
         res_used_in   = used_ff;
         if (sts.need_read) begin
            rd_en = 1'b1;
            if (act_ff == bsa_pkg::ACT_ALLOC) begin
               rd_addr = cur_word;
            end else begin
               rd_addr = idx_ff[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_W];
            end
            word_in = rd_addr;
         end else if (act_ff == bsa_pkg::ACT_ALLOC) begin
            res_status_in = bsa_pkg::ST_FULL;
         end else if (act_ff == bsa_pkg::ACT_CLEAR) begin
            valid_in    = '0;
            cursor_in   = '0;
            used_in     = '0;
            res_used_in = '0;
         end
      end

      // Evaluate the fetched row: commit, or advance to the next word
      if (cmd.eval) begin
         if (act_ff == bsa_pkg::ACT_MARK) begin
            res_slot_in = '0;
            if (mark_hit) begin
               res_status_in = bsa_pkg::ST_OLD_MARK;
               res_used_in   = used_ff;
            end else begin
               wr_en             = 1'b1;
               valid_in[word_ff] = 1'b1;
               used_in           = used_inc;
               res_status_in     = bsa_pkg::ST_NEW_MARK;
               res_used_in       = used_inc;
            end
         end else if (found) begin
            wr_en             = 1'b1;
            valid_in[word_ff] = 1'b1;
            used_in           = used_inc;
            cursor_in         = bsa_pkg::COUNT_W'({word_ff, pos}) + bsa_pkg::COUNT_W'(1);
            res_status_in     = bsa_pkg::ST_ALLOCATED;
            res_slot_in       = {word_ff, pos};
            res_used_in       = used_inc;
         end else if (more) begin
            rd_en   = 1'b1;
            rd_addr = word_ff + bsa_pkg::ADDR_W'(1);
            word_in = rd_addr;
         end else begin
            res_status_in = bsa_pkg::ST_FULL;
            res_slot_in   = '0;
            res_used_in   = used_ff;
         end
      end

      // Hand the result to the output register, drop it once taken
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_slot_in   = res_slot_ff;
         rsp_used_in   = res_used_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= bsa_pkg::COUNT_W'(bsa_pkg::SLOT_COUNT);
         cursor_ff    <= '0;
         used_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slots_ff     <= slots_in;
         cursor_ff    <= cursor_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      idx_ff        <= idx_in;
      word_ff       <= word_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_used_ff   <= res_used_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_found = rsp_slot_ff;
   assign rsp_used_count = rsp_used_ff;

endmodule
`default_nettype wire

FILE: sv/bitmap_slot_allocator.sv
// From accept to rsp_valid, clear, an unknown action or a mark out of range pass START and
// DONE; a mark in range also passes EVAL, and an allocate stays in EVAL while it scans the
// 64-bit words one a cycle (none when the cursor is at or past the slot limit, else 1 to 64).
// One item at a time: the next item is accepted the cycle after the result is registered.
// A waiting result does not block acceptance; DONE holds the next result until it is taken.
// Synchronous reset empties the bitmap at once through per-word valid bits; no clearing pass.
`default_nettype none
module bitmap_slot_allocator (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [bsa_pkg::COUNT_W-1:0]   csr_wr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [bsa_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [bsa_pkg::SLOT_W-1:0]    req_slot_index,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [bsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [bsa_pkg::SLOT_W-1:0]    rsp_slot_found,
   output logic      [bsa_pkg::COUNT_W-1:0]   rsp_used_count
);

   bsa_pkg::cmd_type cmd;
   bsa_pkg::sts_type sts;

   // Sequence each item
   bsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold the bitmap and compute results
   bsa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_action     (req_action),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot_found (rsp_slot_found),
      .rsp_used_count (rsp_used_count),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
`default_nettype wire

FILE: test/slot_alloc_check.sv
// Channel monitor for the bitmap slot allocator: predicts each result and counts mismatches.
module slot_alloc_check (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [bsa_pkg::COUNT_W-1:0]   csr_wr_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [bsa_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [bsa_pkg::SLOT_W-1:0]    req_slot_index,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [bsa_pkg::STATUS_W-1:0]  rsp_status,
   input  wire logic [bsa_pkg::SLOT_W-1:0]    rsp_slot_found,
   input  wire logic [bsa_pkg::COUNT_W-1:0]   rsp_used_count,
   output int                                 mismatch_count,
   output int                                 pending_results
);

   typedef struct packed {
      logic [bsa_pkg::STATUS_W-1:0] status;
      logic [bsa_pkg::SLOT_W-1:0]   slot;
      logic [bsa_pkg::COUNT_W-1:0]  used;
   } alloc_outcome_type;

   // Shadow of the allocator state and its one register
   logic [bsa_pkg::SLOT_COUNT-1:0] slot_busy;
   logic [bsa_pkg::COUNT_W-1:0]    next_search;
   logic [bsa_pkg::COUNT_W-1:0]    busy_count;
   logic [bsa_pkg::COUNT_W-1:0]    region_slots;
   alloc_outcome_type              awaited[$];
   int                             mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 200) begin
         $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   // Apply one item to the shadow state and return the result it should give
   function automatic alloc_outcome_type apply_action(
         input logic [bsa_pkg::ACTION_W-1:0] act,
         input logic [bsa_pkg::SLOT_W-1:0]   idx);
      alloc_outcome_type res;
      int                limit;
      int                i;
      logic              hit;
      limit      = (region_slots > bsa_pkg::SLOT_COUNT) ? bsa_pkg::SLOT_COUNT
                                                        : int'(region_slots);
      res.status = bsa_pkg::ST_OTHER;
      res.slot   = '0;
      hit        = 1'b0;
      case (act)
         bsa_pkg::ACT_ALLOC: begin
            // search upward from the cursor only, never wrapping
            res.status = bsa_pkg::ST_FULL;
            for (i = int'(next_search); i < limit && !hit; i++) begin
               if (!slot_busy[i]) begin
                  hit          = 1'b1;
                  slot_busy[i] = 1'b1;
                  busy_count   = busy_count + 1'b1;
                  next_search  = bsa_pkg::COUNT_W'(i + 1);
                  res.status   = bsa_pkg::ST_ALLOCATED;
                  res.slot     = i[bsa_pkg::SLOT_W-1:0];
               end
            end
         end
         bsa_pkg::ACT_MARK: begin
            if (int'(idx) < limit) begin
               if (slot_busy[idx]) begin
                  res.status = bsa_pkg::ST_OLD_MARK;
               end else begin
                  slot_busy[idx] = 1'b1;
                  busy_count     = busy_count + 1'b1;
                  res.status     = bsa_pkg::ST_NEW_MARK;
               end
            end
         end
         bsa_pkg::ACT_CLEAR: begin
            slot_busy   = '0;
            next_search = '0;
            busy_count  = '0;
         end
         default: begin
         end
      endcase
      res.used = busy_count;
      return res;
   endfunction

   // Compare delivered results, then queue the prediction for a new item
   always @(posedge clock) begin
      alloc_outcome_type want;
      if (reset) begin
         slot_busy       = '0;
         next_search     = '0;
         busy_count      = '0;
         region_slots    = bsa_pkg::COUNT_W'(bsa_pkg::SLOT_COUNT);
         awaited.delete();
         pending_results <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited.size() == 0) begin
               report_mismatch("result with none awaited, status", rsp_status, -1);
            end else begin
               want = awaited.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch("status", rsp_status, want.status);
               end
               if (rsp_slot_found !== want.slot) begin
                  report_mismatch("slot_found", rsp_slot_found, want.slot);
               end
               if (rsp_used_count !== want.used) begin
                  report_mismatch("used_count", rsp_used_count, want.used);
               end
            end
         end
         if (req_valid && req_ready) begin
            awaited.push_back(apply_action(req_action, req_slot_index));
         end
         if (csr_wr_en) begin
            region_slots = csr_wr_data;
         end
         pending_results <= awaited.size();
      end
   end

endmodule

FILE: test/testbench.sv
// Stimulus and verdict for the bitmap slot allocator.
module testbench;

   localparam logic [bsa_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

   logic                         clock;
   logic                         reset          = 1'b1;
   logic                         csr_wr_en      = 1'b0;
   logic [bsa_pkg::COUNT_W-1:0]  csr_wr_data    = '0;
   logic                         req_valid      = 1'b0;
   logic                         req_ready;
   logic [bsa_pkg::ACTION_W-1:0] req_action     = bsa_pkg::ACT_ALLOC;
   logic [bsa_pkg::SLOT_W-1:0]   req_slot_index = '0;
   logic                         rsp_valid;
   logic                         rsp_ready      = 1'b0;
   logic [bsa_pkg::STATUS_W-1:0] rsp_status;
   logic [bsa_pkg::SLOT_W-1:0]   rsp_slot_found;
   logic [bsa_pkg::COUNT_W-1:0]  rsp_used_count;
   int                           mismatch_count;
   int                           pending_results;

   int items_sent   = 0;
   int limit_now    = bsa_pkg::SLOT_COUNT;
   int snd_idle_pct = 33;
   int rsp_idle_pct = 58;
   int hold_asks    = 0;
   int hold_done    = 0;
   int hold_left    = 0;

   bitmap_slot_allocator dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot_found (rsp_slot_found),
      .rsp_used_count (rsp_used_count)
   );

   slot_alloc_check alloc_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot_found  (rsp_slot_found),
      .rsp_used_count  (rsp_used_count),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Backstop against a hung handshake
   initial begin
      #2000000;
      $display("bitmap_slot_allocator test failed");
      $finish;
   end

   // Result side: random stalls, plus a long hold-off whenever one is asked for
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asks != hold_done) begin
            hold_done = hold_asks;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offer one item, after a random gap, and hold it until it is taken
   task automatic send_item(input logic [bsa_pkg::ACTION_W-1:0] act, input int idx);
      if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_slot_index <= idx[bsa_pkg::SLOT_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // Stop offering and wait until every awaited result has been delivered
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the region size once the block is idle
   task automatic set_slots(input int value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[bsa_pkg::COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_now   = (value > bsa_pkg::SLOT_COUNT) ? bsa_pkg::SLOT_COUNT : value;
   endtask

   // Pick a mark index: mostly in range, some at or next to the limit, some anywhere
   function automatic int mark_index;
      int pick;
      int v;
      pick = $urandom_range(9);
      if (pick < 6 && limit_now > 0) begin
         v = $urandom_range(limit_now - 1);
      end else if (pick < 8) begin
         v = limit_now - 2 + $urandom_range(3);
         if (v < 0) v = 0;
         if (v > bsa_pkg::SLOT_COUNT - 1) v = bsa_pkg::SLOT_COUNT - 1;
      end else begin
         v = $urandom_range(bsa_pkg::SLOT_COUNT - 1);
      end
      return v;
   endfunction

   task automatic random_item(input int clear_pct);
      int r;
      r = $urandom_range(99);
      if (r < clear_pct) begin
         send_item(bsa_pkg::ACT_CLEAR, $urandom_range(bsa_pkg::SLOT_COUNT - 1));
      end else if (r < clear_pct + 3) begin
         send_item(ACT_UNUSED, $urandom_range(bsa_pkg::SLOT_COUNT - 1));
      end else if (r < 62) begin
         send_item(bsa_pkg::ACT_ALLOC, $urandom_range(bsa_pkg::SLOT_COUNT - 1));
      end else begin
         send_item(bsa_pkg::ACT_MARK, mark_index());
      end
   endtask

   // Move through the idling schedule as the item count grows
   task automatic pick_idling;
      if (items_sent < 450) begin
         snd_idle_pct = 33;
         rsp_idle_pct <= 58;
      end else if (items_sent < 900) begin
         snd_idle_pct = 58;
         rsp_idle_pct <= 33;
      end else begin
         snd_idle_pct = 0;
         rsp_idle_pct <= 0;
      end
   endtask

   initial begin
      int cfg_menu[15];
      int phase;
      int span;
      int clear_pct;
      logic cleared;
      cfg_menu = '{4096, 1, 64, 65, 8191, 0, 130, 4095, 5000, 37, 200, 2, 127, 4096, 8};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: full region after reset, word edges, top slot, unknown action
      send_item(bsa_pkg::ACT_ALLOC, 0);
      send_item(bsa_pkg::ACT_ALLOC, 4095);
      send_item(bsa_pkg::ACT_MARK, 1);
      send_item(bsa_pkg::ACT_MARK, 4095);
      send_item(bsa_pkg::ACT_MARK, 2);
      send_item(bsa_pkg::ACT_ALLOC, 0);
      send_item(ACT_UNUSED, 4095);
      send_item(bsa_pkg::ACT_CLEAR, 0);
      send_item(bsa_pkg::ACT_MARK, 63);
      send_item(bsa_pkg::ACT_MARK, 64);

      // Directed: empty region, tiny region run to full, saturated register
      set_slots(0);
      send_item(bsa_pkg::ACT_ALLOC, 0);
      send_item(bsa_pkg::ACT_MARK, 0);
      set_slots(3);
      send_item(bsa_pkg::ACT_CLEAR, 0);
      send_item(bsa_pkg::ACT_ALLOC, 0);
      send_item(bsa_pkg::ACT_ALLOC, 0);
      send_item(bsa_pkg::ACT_ALLOC, 0);
      send_item(bsa_pkg::ACT_ALLOC, 0);
      send_item(bsa_pkg::ACT_MARK, 3);
      send_item(bsa_pkg::ACT_MARK, 2);
      set_slots(8191);
      send_item(bsa_pkg::ACT_MARK, 4095);
      send_item(bsa_pkg::ACT_ALLOC, 0);

      // Random phases, each under its own region size
      phase = 0;
      while (items_sent < 1350) begin
         set_slots(cfg_menu[phase % 15]);
         pick_idling();
         cleared = 1'($urandom_range(1));
         if (cleared) begin
            send_item(bsa_pkg::ACT_CLEAR, $urandom_range(bsa_pkg::SLOT_COUNT - 1));
         end
         // keep the receiver back while items keep coming
         if (phase == 2 || phase == 9) begin
            hold_asks <= hold_asks + 1;
         end
         // fill a small region to the end and beyond
         if (cleared && limit_now > 0 && limit_now <= 130) begin
            repeat (limit_now + 2) begin
               send_item(bsa_pkg::ACT_ALLOC, $urandom_range(bsa_pkg::SLOT_COUNT - 1));
            end
         end
         clear_pct = $urandom_range(1) ? 1 : 6;
         span = $urandom_range(40, 110);
         repeat (span) random_item(clear_pct);
         phase++;
      end

      drain();
      repeat (70) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("bitmap_slot_allocator test passed");
      end else begin
         $display("bitmap_slot_allocator test failed");
      end
      $finish;
   end

endmodule
